/* rtl/sipq_pkg.sv */
// shared types, codes and defaults for the sorted-insert priority queue
package sipq_pkg;

   localparam int DEPTH_DEF         = 16;
   localparam int DATA_BITS_DEF     = 32;
   localparam int PRIORITY_BITS_DEF = 16;
   localparam int CAP_BITS          = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   // shift commands broadcast to every cell
   typedef struct packed {
      logic enq;
      logic deq;
   } cell_ctrl_type;

endpackage

/* rtl/sipq_cell.sv */
// one slot of the sorted chain: holds an entry and shifts to either neighbour
module sipq_cell
   import sipq_pkg::*;
#(
   parameter int DATA_BITS     = DATA_BITS_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic [DATA_BITS-1:0]     new_data,
   input  logic [PRIORITY_BITS-1:0] new_prio,
   input  logic                     left_valid,
   input  logic [DATA_BITS-1:0]     left_data,
   input  logic [PRIORITY_BITS-1:0] left_prio,
   input  logic                     left_gt,
   input  logic                     right_valid,
   input  logic [DATA_BITS-1:0]     right_data,
   input  logic [PRIORITY_BITS-1:0] right_prio,
   output logic                     q_valid,
   output logic [DATA_BITS-1:0]     q_data,
   output logic [PRIORITY_BITS-1:0] q_prio,
   output logic                     q_gt,
   output logic                     nxt_valid,
   output logic [DATA_BITS-1:0]     nxt_data,
   output logic [PRIORITY_BITS-1:0] nxt_prio
);

   logic                     valid_ff, valid_in;
   logic [DATA_BITS-1:0]     data_ff, data_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;

   // an empty slot counts as larger than anything
   assign q_gt = !valid_ff || (prio_ff > new_prio);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      prio_in  = prio_ff;
      priority if (ctrl.enq && q_gt && left_gt) begin
         valid_in = left_valid;
         data_in  = left_data;
         prio_in  = left_prio;
      end else if (ctrl.enq && q_gt) begin
         valid_in = 1'b1;
         data_in  = new_data;
         prio_in  = new_prio;
      end else if (ctrl.deq) begin
         valid_in = right_valid;
         data_in  = right_data;
         prio_in  = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign q_valid   = valid_ff;
   assign q_data    = data_ff;
   assign q_prio    = prio_ff;
   assign nxt_valid = valid_in;
   assign nxt_data  = data_in;
   assign nxt_prio  = prio_in;

`ifndef ASSERT_OFF
   // chain stays sorted against the left neighbour
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && left_valid) |-> (left_prio <= prio_ff))
      else $error("cell out of order");
`endif

endmodule

/* rtl/sorted_insert_priority_queue.sv */
// Priority queue kept as a sorted chain of cells, smallest priority at the head.
// req channel: one word per operation, req_op selects enqueue of
//   (req_entry_data, req_entry_priority) or dequeue of the head entry.
// rsp channel: exactly one word per request, carrying status, the dequeued
//   entry, the head entry and the count after the operation.
// csr channel: writes the capacity register (reset 16; a value above DEPTH acts as DEPTH).
// Every cell compares its priority with the incoming one in the same cycle,
// so the cells update at the accepting edge; the response appears in the cycle
// after acceptance and one request can be taken every cycle unless rsp stalls.
// The response register decouples the sides: a new request is taken while
// the held response is being taken; if the receiver stalls, req_ready drops
// until the response is gone. Equal priorities leave in arrival order.
// Reset empties the queue (valid bits only) and sets the capacity to 16.
module sorted_insert_priority_queue
   import sipq_pkg::*;
#(
   parameter int DEPTH         = DEPTH_DEF,
   parameter int DATA_BITS     = DATA_BITS_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
   localparam int CNT_BITS     = $clog2(DEPTH + 1),
   localparam int CMP_BITS     = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic signed [DATA_BITS-1:0]     req_entry_data,
   input  logic [PRIORITY_BITS-1:0]        req_entry_priority,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic signed [DATA_BITS-1:0]     rsp_out_data,
   output logic [PRIORITY_BITS-1:0]        rsp_out_priority,
   output logic                            rsp_head_valid,
   output logic signed [DATA_BITS-1:0]     rsp_head_data,
   output logic [PRIORITY_BITS-1:0]        rsp_head_priority,
   output logic [CNT_BITS-1:0]             rsp_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [CAP_BITS-1:0]             csr_capacity
);

   logic [CAP_BITS-1:0] capacity_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                accept, is_deq, full, empty, enq_ok, deq_ok;
   cell_ctrl_type       ctrl;
   status_type          status;

   logic                     cell_valid [DEPTH];
   logic [DATA_BITS-1:0]     cell_data  [DEPTH];
   logic [PRIORITY_BITS-1:0] cell_prio  [DEPTH];
   logic                     cell_gt    [DEPTH];
   logic                     next_valid [DEPTH];
   logic [DATA_BITS-1:0]     next_data  [DEPTH];
   logic [PRIORITY_BITS-1:0] next_prio  [DEPTH];
   logic [DEPTH-1:0]         valid_vec;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff;
   logic [DATA_BITS-1:0]     out_data_ff;
   logic [PRIORITY_BITS-1:0] out_prio_ff;
   logic                     head_valid_ff;
   logic [DATA_BITS-1:0]     head_data_ff;
   logic [PRIORITY_BITS-1:0] head_prio_ff;
   logic [CNT_BITS-1:0]      rsp_count_ff;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_deq    = (req_op == OP_DEQUEUE);

   assign full   = (CMP_BITS'(count_ff) >= CMP_BITS'(capacity_ff))
                || (count_ff == CNT_BITS'(DEPTH));
   assign empty  = (count_ff == '0);
   assign enq_ok = accept && !is_deq && !full;
   assign deq_ok = accept && is_deq && !empty;

   assign ctrl.enq = enq_ok;
   assign ctrl.deq = deq_ok;

   always_comb begin
      count_in = count_ff;
      priority if (enq_ok) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (deq_ok) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      priority if (is_deq && empty) begin
         status = ST_UNDERFLOW;
      end else if (!is_deq && full) begin
         status = ST_OVERFLOW;
      end else begin
         status = ST_DONE;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     lv, rv, lg;
      logic [DATA_BITS-1:0]     ld, rd;
      logic [PRIORITY_BITS-1:0] lp, rp;

      if (i == 0) begin : g_first
         assign lv = 1'b0;
         assign ld = '0;
         assign lp = '0;
         assign lg = 1'b0;
      end else begin : g_inner_left
         assign lv = cell_valid[i-1];
         assign ld = cell_data[i-1];
         assign lp = cell_prio[i-1];
         assign lg = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign rv = 1'b0;
         assign rd = '0;
         assign rp = '0;
      end else begin : g_inner_right
         assign rv = cell_valid[i+1];
         assign rd = cell_data[i+1];
         assign rp = cell_prio[i+1];
      end

      sipq_cell #(
         .DATA_BITS     (DATA_BITS),
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_data    (req_entry_data),
         .new_prio    (req_entry_priority),
         .left_valid  (lv),
         .left_data   (ld),
         .left_prio   (lp),
         .left_gt     (lg),
         .right_valid (rv),
         .right_data  (rd),
         .right_prio  (rp),
         .q_valid     (cell_valid[i]),
         .q_data      (cell_data[i]),
         .q_prio      (cell_prio[i]),
         .q_gt        (cell_gt[i]),
         .nxt_valid   (next_valid[i]),
         .nxt_data    (next_data[i]),
         .nxt_prio    (next_prio[i])
      );

      assign valid_vec[i] = cell_valid[i];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         status_ff     <= status;
         out_data_ff   <= deq_ok ? cell_data[0] : '0;
         out_prio_ff   <= deq_ok ? cell_prio[0] : '0;
         head_valid_ff <= next_valid[0];
         head_data_ff  <= next_valid[0] ? next_data[0] : '0;
         head_prio_ff  <= next_valid[0] ? next_prio[0] : '0;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_data      = out_data_ff;
   assign rsp_out_priority  = out_prio_ff;
   assign rsp_head_valid    = head_valid_ff;
   assign rsp_head_data     = head_data_ff;
   assign rsp_head_priority = head_prio_ff;
   assign rsp_count         = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("count disagrees with occupied cells");
`endif
`ifndef ASSERT_OFF
   // occupied cells always form a run from the head
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + DEPTH'(1))) == '0)
      else $error("gap in occupied cells");
`endif
`ifndef ASSERT_OFF
   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_deq && full) |=> (count_ff == $past(count_ff)))
      else $error("overflow changed the count");
`endif
`ifndef ASSERT_OFF
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_UNDERFLOW) |-> (rsp_count == '0 && !rsp_head_valid))
      else $error("underflow with entries held");
`endif

endmodule

/* dv/sorted_insert_priority_queue_test.sv */
// testbench for the sorted-insert priority queue: self-checking, with random traffic and stalls
`timescale 1ns / 1ps

module sorted_insert_priority_queue_test;
   import sipq_pkg::*;

   localparam int DEPTH         = DEPTH_DEF;
   localparam int DATA_BITS     = DATA_BITS_DEF;
   localparam int PRIORITY_BITS = PRIORITY_BITS_DEF;
   localparam int CNT_BITS      = $clog2(DEPTH + 1);

   typedef struct {
      status_type                   status;
      logic signed [DATA_BITS-1:0]  out_data;
      logic [PRIORITY_BITS-1:0]     out_priority;
      logic                         head_valid;
      logic signed [DATA_BITS-1:0]  head_data;
      logic [PRIORITY_BITS-1:0]     head_priority;
      logic [CNT_BITS-1:0]          count;
   } queue_outcome_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_op = OP_ENQUEUE;
   logic signed [DATA_BITS-1:0]   req_entry_data = '0;
   logic [PRIORITY_BITS-1:0]      req_entry_priority = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_status;
   logic signed [DATA_BITS-1:0]   rsp_out_data;
   logic [PRIORITY_BITS-1:0]      rsp_out_priority;
   logic                          rsp_head_valid;
   logic signed [DATA_BITS-1:0]   rsp_head_data;
   logic [PRIORITY_BITS-1:0]      rsp_head_priority;
   logic [CNT_BITS-1:0]           rsp_count;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CAP_BITS-1:0]           csr_capacity = '0;

   // predictor state: sorted entries, head at index 0
   logic signed [DATA_BITS-1:0]   held_data [DEPTH];
   logic [PRIORITY_BITS-1:0]      held_prio [DEPTH];
   int                            held_count = 0;
   int                            capacity_setting = CAP_RESET;

   queue_outcome_type             pending_outcomes[$];
   int                            mismatches = 0;
   int                            hold_off_cycles = 0;
   int                            words_sent = 0;
   int                            capacity_writes = 0;
   int                            enqueued = 0;
   int                            dequeued = 0;
   int                            overflows = 0;
   int                            underflows = 0;
   int                            deepest_fill = 0;

   sorted_insert_priority_queue #(
      .DEPTH         (DEPTH),
      .DATA_BITS     (DATA_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_entry_data     (req_entry_data),
      .req_entry_priority (req_entry_priority),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_out_data       (rsp_out_data),
      .rsp_out_priority   (rsp_out_priority),
      .rsp_head_valid     (rsp_head_valid),
      .rsp_head_data      (rsp_head_data),
      .rsp_head_priority  (rsp_head_priority),
      .rsp_count          (rsp_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity       (csr_capacity)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic queue_outcome_type predict_queue_op(input op_type op,
         input logic signed [DATA_BITS-1:0] data, input logic [PRIORITY_BITS-1:0] prio);
      queue_outcome_type res;
      int room;
      int pos;
      res.status       = ST_DONE;
      res.out_data     = '0;
      res.out_priority = '0;
      room = (capacity_setting > DEPTH) ? DEPTH : capacity_setting;
      if (op == OP_ENQUEUE) begin
         if (held_count >= room) begin
            res.status = ST_OVERFLOW;
         end else begin
            // walk down from the tail so equal priorities keep arrival order
            pos = held_count;
            while (pos > 0 && held_prio[pos-1] > prio) begin
               held_data[pos] = held_data[pos-1];
               held_prio[pos] = held_prio[pos-1];
               pos--;
            end
            held_data[pos] = data;
            held_prio[pos] = prio;
            held_count++;
         end
      end else if (held_count == 0) begin
         res.status = ST_UNDERFLOW;
      end else begin
         res.out_data     = held_data[0];
         res.out_priority = held_prio[0];
         for (int k = 1; k < held_count; k++) begin
            held_data[k-1] = held_data[k];
            held_prio[k-1] = held_prio[k];
         end
         held_count--;
      end
      res.head_valid    = (held_count > 0);
      res.head_data     = (held_count > 0) ? held_data[0] : '0;
      res.head_priority = (held_count > 0) ? held_prio[0] : '0;
      res.count         = CNT_BITS'(held_count);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
         input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      queue_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected word, status", rsp_status, '0);
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", rsp_status, want.status);
            check_field("out_data", rsp_out_data, want.out_data);
            check_field("out_priority", rsp_out_priority, want.out_priority);
            check_field("head_valid", rsp_head_valid, want.head_valid);
            check_field("head_data", rsp_head_data, want.head_data);
            check_field("head_priority", rsp_head_priority, want.head_priority);
            check_field("count", rsp_count, want.count);
            unique case (want.status)
               ST_OVERFLOW:  overflows++;
               ST_UNDERFLOW: underflows++;
               default: ;
            endcase
            if (want.count > deepest_fill) begin
               deepest_fill = want.count;
            end
         end
      end
   end

   // receiver: stall pattern changes every stretch, long hold-off on request
   initial begin : receiver
      int mode;
      int stretch;
      mode    = 0;
      stretch = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            if (stretch == 0) begin
               mode    = $urandom_range(0, 2);
               stretch = $urandom_range(20, 150);
            end
            stretch--;
            unique case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_word(input op_type op, input logic signed [DATA_BITS-1:0] data,
         input logic [PRIORITY_BITS-1:0] prio);
      req_valid          <= 1'b1;
      req_op             <= op;
      req_entry_data     <= data;
      req_entry_priority <= prio;
      do @(posedge clock); while (!req_ready);
      pending_outcomes.push_back(predict_queue_op(op, data, prio));
      words_sent++;
      if (op == OP_ENQUEUE) begin
         enqueued++;
      end else begin
         dequeued++;
      end
      @(negedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_valid    <= 1'b1;
      csr_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      capacity_setting = value;
      capacity_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // reset capacity: empty queue, field extremes and a priority tie
   task automatic test_extremes_and_ties;
      send_word(OP_DEQUEUE, 32'sh7fff_ffff, 16'hffff);
      send_word(OP_ENQUEUE, 32'sh8000_0000, 16'hffff);
      send_word(OP_ENQUEUE, 32'sh7fff_ffff, 16'h0000);
      send_word(OP_ENQUEUE, 32'sh5555_5555, 16'h0000);
      send_word(OP_ENQUEUE, -32'sd1, 16'h8000);
      repeat (4) send_word(OP_DEQUEUE, '0, '0);
      send_word(OP_DEQUEUE, -32'sd1, 16'h0000);
   endtask

   task automatic test_capacity_limits;
      write_capacity(5'd1);
      send_word(OP_ENQUEUE, 32'sd1, 16'd5);
      send_word(OP_ENQUEUE, 32'sd2, 16'd3);
      send_word(OP_DEQUEUE, '0, '0);
      send_word(OP_DEQUEUE, '0, '0);
      // zero capacity means always full
      write_capacity(5'd0);
      send_word(OP_ENQUEUE, 32'sd3, 16'd1);
   endtask

   task automatic test_capacity_below_count;
      write_capacity(5'd16);
      send_word(OP_ENQUEUE, 32'sd10, 16'd7);
      send_word(OP_ENQUEUE, 32'sd11, 16'd7);
      send_word(OP_ENQUEUE, 32'sd12, 16'd2);
      // held entries stay after the limit drops under the count
      write_capacity(5'd2);
      send_word(OP_ENQUEUE, 32'sd13, 16'd1);
      send_word(OP_DEQUEUE, '0, '0);
      send_word(OP_ENQUEUE, 32'sd14, 16'd1);
      send_word(OP_DEQUEUE, '0, '0);
      send_word(OP_ENQUEUE, 32'sd15, 16'd9);
      send_word(OP_DEQUEUE, '0, '0);
      send_word(OP_DEQUEUE, '0, '0);
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure(input int words);
      write_capacity(5'd16);
      hold_off_cycles = $urandom_range(60, 120);
      repeat (words) begin
         send_word(OP_ENQUEUE, $urandom(), PRIORITY_BITS'($urandom_range(0, 7)));
      end
      repeat (words) begin
         send_word(OP_DEQUEUE, $urandom(), PRIORITY_BITS'($urandom()));
      end
   endtask

   task automatic test_random_traffic(input logic [CAP_BITS-1:0] cap, input int words);
      int sent;
      int burst;
      int enq_percent;
      int prio_mode;
      logic [PRIORITY_BITS-1:0] prio;
      op_type op;
      write_capacity(cap);
      sent = 0;
      while (sent < words) begin
         burst       = $urandom_range(1, 24);
         enq_percent = $urandom_range(20, 80);
         prio_mode   = $urandom_range(0, 2);
         for (int k = 0; k < burst && sent < words; k++) begin
            op = ($urandom_range(0, 99) < enq_percent) ? OP_ENQUEUE : OP_DEQUEUE;
            unique case (prio_mode)
               0:       prio = PRIORITY_BITS'($urandom_range(0, 3));
               1:       prio = PRIORITY_BITS'($urandom());
               default: prio = $urandom_range(0, 1) ? '1 : '0;
            endcase
            send_word(op, $urandom(), prio);
            sent++;
         end
         // about a third of bursts run straight on into the next
         if ($urandom_range(0, 2) != 0) begin
            idle_sender($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_extremes_and_ties();
      test_capacity_limits();
      test_capacity_below_count();
      test_backpressure(24);

      test_random_traffic(5'd16, 300);
      test_random_traffic(5'd31, 250);
      test_random_traffic(5'd17, 200);
      test_random_traffic(5'd3, 200);
      test_random_traffic(5'd1, 150);
      test_random_traffic(5'd0, 40);
      test_random_traffic(5'd2, 150);
      test_backpressure(20);
      repeat (5) begin
         test_random_traffic(CAP_BITS'($urandom_range(0, 31)), 150);
      end

      req_valid <= 1'b0;
      for (int n = 0; n < 5000 && pending_outcomes.size() != 0; n++) begin
         @(negedge clock);
      end
      if (pending_outcomes.size() != 0) begin
         report_mismatch("words never returned", pending_outcomes.size(), '0);
      end
      repeat (10) @(negedge clock);

      $display("%0d words sent: %0d enqueues, %0d dequeues, %0d overflows, %0d underflows",
               words_sent, enqueued, dequeued, overflows, underflows);
      $display("%0d capacity writes, deepest fill %0d entries, %0d mismatches",
               capacity_writes, deepest_fill, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("timeout with %0d words outstanding", pending_outcomes.size());
      $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/sipq_pkg.sv
rtl/sipq_cell.sv
rtl/sorted_insert_priority_queue.sv
dv/sorted_insert_priority_queue_test.sv
